// ----- design/stx_decimal_binary_record_parser_macros.svh -----
// Assertion helpers shared by the parser blocks.
`ifndef STX_DECIMAL_BINARY_RECORD_PARSER_MACROS_SVH
`define STX_DECIMAL_BINARY_RECORD_PARSER_MACROS_SVH

// Check a property on every clock outside reset.
`define STX_DBRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock, reset cycles included.
`define STX_DBRP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/stx_dbrp_pkg.sv -----
package stx_dbrp_pkg;

    localparam int ADDRESS_WIDTH = 32;

    // Result queue; depth must be a power of two so the pointers wrap.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_STX   = 8'h02;
    localparam logic [7:0] CHAR_ETX   = 8'h03;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ST_RECORD   = 3'd0,
        ST_END      = 3'd1,
        ST_GARBAGE  = 3'd2,
        ST_NO_START = 3'd3,
        ST_NO_DATA  = 3'd4,
        ST_ADDR_EXP = 3'd5,
        ST_DATA_EXP = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        PH_SEEK     = 3'd0,
        PH_GAP      = 3'd1,
        PH_ADDR     = 3'd2,
        PH_PRE_DATA = 3'd3,
        PH_DATA     = 3'd4,
        PH_DONE     = 3'd5,
        PH_STOP     = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] record_address;
        logic [7:0]  record_data;
        logic        last_of_run;
    } out_item_t;

    // Results of one parse step: zero, one or two items.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } step_res_t;

endpackage

// ----- design/stx_dbrp_parser.sv -----
`include "stx_decimal_binary_record_parser_macros.svh"

module stx_dbrp_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    fire,
    input  stx_dbrp_pkg::in_item_t  item,
    output stx_dbrp_pkg::step_res_t res
);
    import stx_dbrp_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [ADDRESS_WIDTH-1:0] addr_acc_reg, addr_acc_next;
    logic [7:0]               data_acc_reg, data_acc_next;
    logic                     seen_reg, seen_next;
    logic                     warned_reg, warned_next;

    logic [7:0]                ch;
    logic                      eos;
    logic                      ch_space, ch_digit, ch_bit, term;
    logic [ADDRESS_WIDTH-1:0]  digit_val, addr_times_ten;
    logic [ADDRESS_WIDTH+31:0] addr_ext;
    logic [1:0]                cnt;
    out_item_t                 r0, r1;

    assign ch        = item.in_char;
    assign eos       = item.stream_end;
    assign ch_space  = (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
    assign ch_digit  = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign ch_bit    = (ch == CHAR_ZERO) || (ch == CHAR_ONE);
    assign term      = eos || (ch == CHAR_ETX);
    assign digit_val = ADDRESS_WIDTH'(ch[3:0]);
    assign addr_times_ten = (addr_acc_reg << 3) + (addr_acc_reg << 1) + digit_val;
    assign addr_ext  = {32'd0, addr_acc_reg};

    always_comb begin
        phase_next    = phase_reg;
        addr_acc_next = addr_acc_reg;
        data_acc_next = data_acc_reg;
        seen_next     = seen_reg;
        warned_next   = warned_reg;
        cnt           = 2'd0;
        r0            = '0;
        r1            = '0;
        case (phase_reg)
            PH_SEEK: begin
                if (eos) begin
                    r0.status  = ST_NO_START;
                    cnt        = 2'd1;
                    phase_next = PH_STOP;
                end else if (ch == CHAR_STX) begin
                    phase_next = PH_GAP;
                end else if (!warned_reg) begin
                    warned_next = 1'b1;
                    r0.status   = ST_GARBAGE;
                    cnt         = 2'd1;
                end
            end
            PH_GAP: begin
                if (term) begin
                    cnt = 2'd1;
                    if (seen_reg) begin
                        r0.status  = ST_END;
                        phase_next = PH_DONE;
                    end else begin
                        r0.status  = ST_NO_DATA;
                        phase_next = PH_STOP;
                    end
                end else if (ch_space) begin
                    phase_next = PH_GAP;
                end else if (ch_digit) begin
                    addr_acc_next = digit_val;
                    phase_next    = PH_ADDR;
                end else begin
                    r0.status  = ST_ADDR_EXP;
                    cnt        = 2'd1;
                    phase_next = PH_STOP;
                end
            end
            PH_ADDR: begin
                if (!eos && ch_digit) begin
                    addr_acc_next = addr_times_ten;
                end else if (!eos && ch_space) begin
                    phase_next = PH_PRE_DATA;
                end else if (!eos && ch_bit) begin
                    data_acc_next = {7'd0, ch[0]};
                    phase_next    = PH_DATA;
                end else begin
                    r0.status  = ST_DATA_EXP;
                    cnt        = 2'd1;
                    phase_next = PH_STOP;
                end
            end
            PH_PRE_DATA: begin
                if (!eos && ch_space) begin
                    phase_next = PH_PRE_DATA;
                end else if (!eos && ch_bit) begin
                    data_acc_next = {7'd0, ch[0]};
                    phase_next    = PH_DATA;
                end else begin
                    r0.status  = ST_DATA_EXP;
                    cnt        = 2'd1;
                    phase_next = PH_STOP;
                end
            end
            PH_DATA: begin
                if (!eos && ch_bit) begin
                    data_acc_next = {data_acc_reg[6:0], ch[0]};
                end else begin
                    // Close the record, then treat the same character as a gap one.
                    r0.status         = ST_RECORD;
                    r0.record_address = addr_ext[31:0];
                    r0.record_data    = data_acc_reg;
                    cnt               = 2'd1;
                    seen_next         = 1'b1;
                    phase_next        = PH_GAP;
                    if (term) begin
                        r1.status  = ST_END;
                        cnt        = 2'd2;
                        phase_next = PH_DONE;
                    end else if (ch_space) begin
                        phase_next = PH_GAP;
                    end else if (ch_digit) begin
                        addr_acc_next = digit_val;
                        phase_next    = PH_ADDR;
                    end else begin
                        r1.status  = ST_ADDR_EXP;
                        cnt        = 2'd2;
                        phase_next = PH_STOP;
                    end
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
        if (cnt == 2'd1) begin
            r0.last_of_run = 1'b1;
        end
        if (cnt == 2'd2) begin
            r1.last_of_run = 1'b1;
        end
    end

    assign res.count  = cnt;
    assign res.first  = r0;
    assign res.second = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SEEK;
            addr_acc_reg <= '0;
            data_acc_reg <= '0;
            seen_reg     <= 1'b0;
            warned_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            addr_acc_reg <= addr_acc_next;
            data_acc_reg <= data_acc_next;
            seen_reg     <= seen_next;
            warned_reg   <= warned_next;
        end
    end

    `STX_DBRP_ASSERT(a_final_phase_holds, (phase_reg == PH_DONE || phase_reg == PH_STOP) |=> $stable(phase_reg), "parser left a final phase")
    `STX_DBRP_ASSERT(a_pair_starts_record, (res.count == 2'd2) |-> (res.first.status == ST_RECORD), "two results without a leading record")
    `STX_DBRP_ASSERT(a_warn_sticky, warned_reg |=> warned_reg, "garbage warning flag cleared")

endmodule

// ----- design/stx_dbrp_result_fifo.sv -----
`include "stx_decimal_binary_record_parser_macros.svh"

module stx_dbrp_result_fifo (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  push,
    input  stx_dbrp_pkg::step_res_t               res_in,
    output logic [stx_dbrp_pkg::FIFO_CNT_W-1:0]   free_cnt,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output stx_dbrp_pkg::out_item_t               m_item
);
    import stx_dbrp_pkg::*;

    out_item_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [1:0]            push_n;
    logic                  pop;

    assign push_n   = push ? res_in.count : 2'd0;
    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_item   = mem_reg[rd_ptr_reg];
    assign free_cnt = FIFO_CNT_W'(FIFO_DEPTH) - count_reg;

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= res_in.first;
        end
        if (push_n == 2'd2) begin
            mem_reg[FIFO_PTR_W'(wr_ptr_reg + 1'b1)] <= res_in.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `STX_DBRP_ASSERT_RST(a_empty_after_reset, !aresetn |=> (count_reg == '0), "queue not empty after reset")
    `STX_DBRP_ASSERT(a_count_bound, count_reg <= FIFO_CNT_W'(FIFO_DEPTH), "queue count beyond depth")
    `STX_DBRP_ASSERT(a_no_overflow, (push_n != 2'd0) |-> (FIFO_CNT_W'(push_n) <= free_cnt), "push into a full queue")
    `STX_DBRP_ASSERT(a_pop_only_drains, (pop && push_n == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1), "pop did not drain one entry")

endmodule

// ----- design/stx_decimal_binary_record_parser.sv -----
// Load-file record parser: takes one character (or an end-of-stream marker) per item
// and returns records (decimal address, binary data byte), an end result, a one-time
// garbage warning or a sticky error. One input item can be accepted every cycle while
// the queue has room; the item is held in an input register, parsed in a single pass
// against the parser state, and its zero, one or two results are written into a
// 4-entry result queue that drives the result channel. Each item passes the input
// register, and its results the result queue, before they reach the result channel. An
// item is taken whenever the queue has room for the results it causes, so the input
// runs at one item per cycle as long as the result channel takes one result per cycle;
// an item that ends a record with an end byte or an error gives two results. After the
// end result or an error the block ignores further input until reset.
module stx_decimal_binary_record_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  stx_dbrp_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output stx_dbrp_pkg::out_item_t m_item
);
    import stx_dbrp_pkg::*;

    logic                  s1_valid_reg;
    in_item_t              s1_item_reg;
    step_res_t             step_res;
    logic [FIFO_CNT_W-1:0] free_cnt;
    logic                  fire;

    // Advance the held item once the queue can take all of its results.
    assign fire    = s1_valid_reg && (free_cnt >= FIFO_CNT_W'(step_res.count));
    assign s_ready = !s1_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    // Hold the payload while stalled; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_item_reg <= s_item;
        end
    end

    stx_dbrp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (s1_item_reg),
        .res     (step_res)
    );

    stx_dbrp_result_fifo u_result_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fire),
        .res_in   (step_res),
        .free_cnt (free_cnt),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
